@@ rtl/pps_pkg.sv @@
`timescale 1ns / 1ps

package pps_pkg;

  // Width of the slot field on the request channel.
  localparam int unsigned SLOT_W = 4;

  // Request kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

endpackage

@@ rtl/pps_if.sv @@
`timescale 1ns / 1ps

interface pps_in_if import pps_pkg::*; #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned PRIO_BITS = 8
) ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [SLOT_W-1:0]    slot;
  logic [TIME_BITS-1:0] arrival_time;
  logic [TIME_BITS-1:0] burst_length;
  logic [PRIO_BITS-1:0] task_priority;

  modport source (
    output valid, kind, slot, arrival_time, burst_length, task_priority,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, arrival_time, burst_length, task_priority,
    output ready
  );
endinterface

interface pps_out_if import pps_pkg::*; #(
  parameter int unsigned TIME_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] tick_end_time;
  logic [SLOT_W-1:0]    running_slot;
  logic                 idle;
  logic                 finished;
  logic [TIME_BITS-1:0] turnaround;
  logic [TIME_BITS-1:0] waiting;
  logic                 all_done;

  modport source (
    output valid, tick_end_time, running_slot, idle, finished, turnaround, waiting,
           all_done,
    input  ready
  );
  modport sink (
    input  valid, tick_end_time, running_slot, idle, finished, turnaround, waiting,
           all_done,
    output ready
  );
endinterface

@@ rtl/preemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps

// Preemptive priority scheduler. A load request writes one task slot (arrival time, burst
// length, priority) and gives no result. A tick request sends a best-candidate token along
// the row of slot cells one cell per cycle, picking the ready task with the smallest priority
// value (lowest slot on a tie), then the chosen task is charged one unit, time advances by one
// (saturating), and the result is registered. One request is in flight at a time; a finished
// result may wait on the output while the next request is taken.
module preemptive_priority_scheduler import pps_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pps_in_if.sink     task_i,
  pps_out_if.source  res_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } state_e;

  state_e state_q;

  logic [TIME_BITS-1:0] time_q;
  logic                 found_q;
  logic [IDX_W-1:0]     idx_q;
  logic [TIME_BITS-1:0] arr_q;
  logic [TIME_BITS-1:0] burst_q;
  logic [TIME_BITS-1:0] rem_q;
  logic                 fin_q;
  logic [TIME_BITS-1:0] turn_q;

  logic                 res_valid_q;
  logic [TIME_BITS-1:0] res_time_q;
  logic [SLOT_W-1:0]    res_slot_q;
  logic                 res_idle_q;
  logic                 res_fin_q;
  logic [TIME_BITS-1:0] res_turn_q;
  logic [TIME_BITS-1:0] res_wait_q;
  logic                 res_done_q;

  logic                 accept;
  logic                 wr_en;
  logic                 dec_en;
  logic [TIME_BITS-1:0] time_inc;
  logic                 out_free;

  logic                 tok_vld   [NUM_SLOTS+1];
  logic                 tok_found [NUM_SLOTS+1];
  logic [PRIO_BITS-1:0] tok_prio  [NUM_SLOTS+1];
  logic [IDX_W-1:0]     tok_idx   [NUM_SLOTS+1];
  logic [TIME_BITS-1:0] tok_arr   [NUM_SLOTS+1];
  logic [TIME_BITS-1:0] tok_burst [NUM_SLOTS+1];
  logic [TIME_BITS-1:0] tok_rem   [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] has_work;

  assign task_i.ready = (state_q == S_IDLE);
  assign accept       = task_i.valid && task_i.ready;
  assign wr_en        = accept && (task_i.kind == KIND_LOAD);
  assign dec_en       = (state_q == S_UPDATE) && found_q;
  assign time_inc     = (time_q == '1) ? time_q : time_q + 1'b1;
  assign out_free     = !res_valid_q || res_o.ready;

  assign tok_vld[0]   = accept && (task_i.kind == KIND_TICK);
  assign tok_found[0] = 1'b0;
  assign tok_prio[0]  = '0;
  assign tok_idx[0]   = '0;
  assign tok_arr[0]   = '0;
  assign tok_burst[0] = '0;
  assign tok_rem[0]   = '0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    pps_cell #(
      .IDX       (g),
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_BITS (TIME_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (wr_en),
      .wr_slot_i   (task_i.slot),
      .wr_arr_i    (task_i.arrival_time),
      .wr_burst_i  (task_i.burst_length),
      .wr_prio_i   (task_i.task_priority),
      .dec_en_i    (dec_en),
      .dec_idx_i   (idx_q),
      .cur_time_i  (time_q),
      .tok_vld_i   (tok_vld[g]),
      .tok_found_i (tok_found[g]),
      .tok_prio_i  (tok_prio[g]),
      .tok_idx_i   (tok_idx[g]),
      .tok_arr_i   (tok_arr[g]),
      .tok_burst_i (tok_burst[g]),
      .tok_rem_i   (tok_rem[g]),
      .tok_vld_o   (tok_vld[g+1]),
      .tok_found_o (tok_found[g+1]),
      .tok_prio_o  (tok_prio[g+1]),
      .tok_idx_o   (tok_idx[g+1]),
      .tok_arr_o   (tok_arr[g+1]),
      .tok_burst_o (tok_burst[g+1]),
      .tok_rem_o   (tok_rem[g+1]),
      .has_work_o  (has_work[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      arr_q       <= '0;
      burst_q     <= '0;
      rem_q       <= '0;
      fin_q       <= 1'b0;
      turn_q      <= '0;
      res_valid_q <= 1'b0;
      res_time_q  <= '0;
      res_slot_q  <= '0;
      res_idle_q  <= 1'b0;
      res_fin_q   <= 1'b0;
      res_turn_q  <= '0;
      res_wait_q  <= '0;
      res_done_q  <= 1'b0;
    end else begin
      // In S_FINISH the output register is handled below.
      if (res_valid_q && res_o.ready && (state_q != S_FINISH)) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (tok_vld[0]) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok_vld[NUM_SLOTS]) begin
            found_q <= tok_found[NUM_SLOTS];
            idx_q   <= tok_idx[NUM_SLOTS];
            arr_q   <= tok_arr[NUM_SLOTS];
            burst_q <= tok_burst[NUM_SLOTS];
            rem_q   <= tok_rem[NUM_SLOTS];
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // The chosen cell is charged this cycle; time moves on even when idle.
          time_q  <= time_inc;
          fin_q   <= found_q && (rem_q == TIME_BITS'(1));
          turn_q  <= time_inc - arr_q;
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            res_valid_q <= 1'b1;
            res_time_q  <= time_q;
            res_slot_q  <= found_q ? SLOT_W'(idx_q) : '0;
            res_idle_q  <= !found_q;
            res_fin_q   <= fin_q;
            res_turn_q  <= fin_q ? turn_q : '0;
            res_wait_q  <= (fin_q && (turn_q >= burst_q)) ? turn_q - burst_q : '0;
            res_done_q  <= ~|has_work;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.tick_end_time = res_time_q;
  assign res_o.running_slot  = res_slot_q;
  assign res_o.idle          = res_idle_q;
  assign res_o.finished      = res_fin_q;
  assign res_o.turnaround    = res_turn_q;
  assign res_o.waiting       = res_wait_q;
  assign res_o.all_done      = res_done_q;

endmodule

@@ rtl/pps_cell.sv @@
`timescale 1ns / 1ps

module pps_cell import pps_pkg::*; #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned PRIO_BITS = 8,
  localparam int unsigned IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Load broadcast.
  input  logic                 wr_en_i,
  input  logic [SLOT_W-1:0]    wr_slot_i,
  input  logic [TIME_BITS-1:0] wr_arr_i,
  input  logic [TIME_BITS-1:0] wr_burst_i,
  input  logic [PRIO_BITS-1:0] wr_prio_i,
  // Service broadcast.
  input  logic                 dec_en_i,
  input  logic [IDX_W-1:0]     dec_idx_i,
  input  logic [TIME_BITS-1:0] cur_time_i,
  // Best-candidate token from the previous cell.
  input  logic                 tok_vld_i,
  input  logic                 tok_found_i,
  input  logic [PRIO_BITS-1:0] tok_prio_i,
  input  logic [IDX_W-1:0]     tok_idx_i,
  input  logic [TIME_BITS-1:0] tok_arr_i,
  input  logic [TIME_BITS-1:0] tok_burst_i,
  input  logic [TIME_BITS-1:0] tok_rem_i,
  // Token to the next cell.
  output logic                 tok_vld_o,
  output logic                 tok_found_o,
  output logic [PRIO_BITS-1:0] tok_prio_o,
  output logic [IDX_W-1:0]     tok_idx_o,
  output logic [TIME_BITS-1:0] tok_arr_o,
  output logic [TIME_BITS-1:0] tok_burst_o,
  output logic [TIME_BITS-1:0] tok_rem_o,
  output logic                 has_work_o
);

  logic                 loaded_q;
  logic [TIME_BITS-1:0] arr_q;
  logic [TIME_BITS-1:0] burst_q;
  logic [TIME_BITS-1:0] rem_q;
  logic [PRIO_BITS-1:0] prio_q;

  logic                 tok_vld_q;
  logic                 tok_found_q;
  logic [PRIO_BITS-1:0] tok_prio_q;
  logic [IDX_W-1:0]     tok_idx_q;
  logic [TIME_BITS-1:0] tok_arr_q;
  logic [TIME_BITS-1:0] tok_burst_q;
  logic [TIME_BITS-1:0] tok_rem_q;

  logic wr_hit;
  logic dec_hit;
  logic eligible;
  logic take;

  assign wr_hit   = wr_en_i && (32'(wr_slot_i) == IDX);
  assign dec_hit  = dec_en_i && (dec_idx_i == IDX_W'(IDX));
  assign eligible = loaded_q && (rem_q != '0) && (arr_q <= cur_time_i);
  // Strict compare keeps an earlier slot on equal priority.
  assign take     = eligible && (!tok_found_i || (prio_q < tok_prio_i));

  assign has_work_o = loaded_q && (rem_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
      if (wr_hit) begin
        loaded_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      arr_q   <= wr_arr_i;
      burst_q <= wr_burst_i;
      rem_q   <= wr_burst_i;
      prio_q  <= wr_prio_i;
    end else if (dec_hit) begin
      rem_q <= rem_q - 1'b1;
    end

    if (take) begin
      tok_found_q <= 1'b1;
      tok_prio_q  <= prio_q;
      tok_idx_q   <= IDX_W'(IDX);
      tok_arr_q   <= arr_q;
      tok_burst_q <= burst_q;
      tok_rem_q   <= rem_q;
    end else begin
      tok_found_q <= tok_found_i;
      tok_prio_q  <= tok_prio_i;
      tok_idx_q   <= tok_idx_i;
      tok_arr_q   <= tok_arr_i;
      tok_burst_q <= tok_burst_i;
      tok_rem_q   <= tok_rem_i;
    end
  end

  assign tok_vld_o   = tok_vld_q;
  assign tok_found_o = tok_found_q;
  assign tok_prio_o  = tok_prio_q;
  assign tok_idx_o   = tok_idx_q;
  assign tok_arr_o   = tok_arr_q;
  assign tok_burst_o = tok_burst_q;
  assign tok_rem_o   = tok_rem_q;

endmodule
